/* sv/pewb_pkg.sv */
// pewb_pkg: shared types, constants and defaults for the prewitt edge binarizer
// used by pewb_cell and prewitt_edge_binarize_top; depends on nothing

package pewb_pkg;

  // default sizes of the line stores and the frame
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // field widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned FW_W     = 12;  // frame_width register field
  localparam int unsigned FH_W     = 13;  // frame_height register field
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // window arithmetic widths
  localparam int unsigned SUM_W  = 10;  // sum of three pixels
  localparam int unsigned DIFF_W = 9;   // signed bottom minus top
  localparam int unsigned G_W    = 11;  // signed gradient
  localparam int unsigned ABS_W  = 10;  // |gradient|, at most 765
  localparam int unsigned PROD_W = 20;

  // floor(a / 3) = (a * 683) >> 11 for every a below 2048
  localparam logic [PROD_W-1:0] DIV3_MUL = 20'd683;
  localparam int unsigned       DIV3_SH  = 11;

  // register reset values
  localparam int unsigned FRAME_WIDTH_RST  = 512;
  localparam int unsigned FRAME_HEIGHT_RST = 512;
  localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd40;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  // input action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             action;    // 0 = pixel, 1 = flush
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [PIX_W-1:0] edge_magnitude;
    logic             frame_last;
  } out_item_t;

  // one window column, top row oldest
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

endpackage

/* sv/prewitt_edge_binarize_top.sv */
// prewitt_edge_binarize_top: streaming 3x3 prewitt edge detector with binarization
// depends on pewb_pkg, pewb_ram (two line stores) and pewb_cell (window columns)

// One item is taken per clock unless the output stalls: a pixel or a flush
// transfer can follow in the very next cycle, and each result passes the line
// store read, the window, the absolute gradients and the output register.
// The rate is set by the line stores, two RAMs of MAX_WIDTH bytes read at the
// transfer and written back when the item moves on, and by the window, three
// column cells that shift once per pixel. Results lag the pixel stream by one
// row plus one pixel; after the last pixel of a frame, frame_width + 1 flush
// items drain it, the last one carrying frame_last. Writing frame_width or
// frame_height restarts the frame; threshold applies at once. The line stores
// need no clearing: a read of an entry not yet written is masked to zero.

module prewitt_edge_binarize_top #(
  parameter int unsigned MAX_WIDTH  = pewb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pewb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pewb_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pewb_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pewb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pewb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned F_W   = $clog2(MAX_WIDTH + 2);
  localparam int unsigned PW    = pewb_pkg::PIX_W;

  localparam int unsigned W_RST = (pewb_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                                  MAX_WIDTH : pewb_pkg::FRAME_WIDTH_RST;
  localparam int unsigned H_RST = (pewb_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                                  MAX_HEIGHT : pewb_pkg::FRAME_HEIGHT_RST;

  typedef struct packed {
    logic             pix;    // pixel, else flush
    logic             emit;
    logic             inner;
    logic             ab1;    // row above is valid
    logic             ab2;    // row two above is valid
    logic             last;
    logic [PW-1:0]    p;
    logic [COL_W-1:0] col;
  } s1_t;

  // ---------------- configuration ----------------
  logic [W_W-1:0] w_q;
  logic [H_W-1:0] h_q;
  logic [PW-1:0]  thr_q;
  logic           cfg_we;
  logic           restart;
  logic [pewb_pkg::FW_W-1:0] cfg_w;
  logic [pewb_pkg::FH_W-1:0] cfg_h;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_w       = cfg_data_i[pewb_pkg::FW_W-1:0];
  assign cfg_h       = cfg_data_i[pewb_pkg::FH_W-1:0];
  assign restart     = cfg_we && ((cfg_index_i == pewb_pkg::CFG_FRAME_WIDTH)
                               || (cfg_index_i == pewb_pkg::CFG_FRAME_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= W_W'(W_RST);
      h_q   <= H_W'(H_RST);
      thr_q <= pewb_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        pewb_pkg::CFG_FRAME_WIDTH: begin
          if (int'(cfg_w) < 3) begin
            w_q <= W_W'(3);
          end else if (int'(cfg_w) > int'(MAX_WIDTH)) begin
            w_q <= W_W'(MAX_WIDTH);
          end else begin
            w_q <= W_W'(cfg_w);
          end
        end
        pewb_pkg::CFG_FRAME_HEIGHT: begin
          if (int'(cfg_h) < 3) begin
            h_q <= H_W'(3);
          end else if (int'(cfg_h) > int'(MAX_HEIGHT)) begin
            h_q <= H_W'(MAX_HEIGHT);
          end else begin
            h_q <= H_W'(cfg_h);
          end
        end
        pewb_pkg::CFG_THRESHOLD: begin
          thr_q <= cfg_data_i[PW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic acc;

  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign acc        = in_valid_i && rdy1;

  // ---------------- position counters ----------------
  logic [COL_W-1:0] col_q;
  logic [H_W-1:0]   row_q;
  logic [F_W-1:0]   flush_q;   // flush results still owed once the frame is in
  logic is_pix, is_flush, last_col, last_row, flush_last;

  always_comb begin
    is_pix     = (in_data_i.action == pewb_pkg::ACT_PIXEL) && (row_q < h_q);
    is_flush   = (in_data_i.action == pewb_pkg::ACT_FLUSH) && (row_q == h_q)
               && (flush_q != '0);
    flush_last = (flush_q == F_W'(1));
    last_col   = (col_q == COL_W'(w_q - W_W'(1)));
    last_row   = (row_q == h_q - H_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else if (restart) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else if (acc && is_pix) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= row_q + H_W'(1);
        if (last_row) begin
          flush_q <= F_W'(w_q) + F_W'(1);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end else if (acc && is_flush) begin
      flush_q <= flush_q - F_W'(1);
      if (flush_last) begin
        row_q <= '0;
        col_q <= '0;
      end
    end
  end

  // ---------------- stage 1: line store read ----------------
  s1_t s1_q;
  logic [PW-1:0] ls0_rdata, ls1_rdata;
  logic [PW-1:0] above, above2;
  logic          ram_re, ram_we, shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= acc && (is_pix || is_flush);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_q.pix   <= is_pix;
      s1_q.emit  <= (row_q >= H_W'(2)) || ((row_q == H_W'(1)) && (col_q != '0));
      s1_q.inner <= (row_q >= H_W'(2)) && (col_q >= COL_W'(2));
      s1_q.ab1   <= (row_q >= H_W'(1));
      s1_q.ab2   <= (row_q >= H_W'(2));
      s1_q.last  <= flush_last;
      s1_q.p     <= in_data_i.pixel_in;
      s1_q.col   <= col_q;
    end
  end

  assign ram_re = acc && is_pix;
  assign shift  = v1_q && rdy2 && s1_q.pix;
  assign ram_we = shift;
  assign above  = s1_q.ab1 ? ls0_rdata : '0;
  assign above2 = s1_q.ab2 ? ls1_rdata : '0;

  // row above the incoming pixel
  pewb_ram #(.DATA_W(PW), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.col),
    .wdata_i (s1_q.p),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ls0_rdata)
  );

  // row two above
  pewb_ram #(.DATA_W(PW), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.col),
    .wdata_i (above),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ls1_rdata)
  );

  // ---------------- window: chain of column cells ----------------
  pewb_pkg::pix_col_t new_col;
  pewb_pkg::pix_col_t cell_col [3];
  logic [pewb_pkg::SUM_W-1:0]         cell_sum  [3];
  logic signed [pewb_pkg::DIFF_W-1:0] cell_diff [3];

  assign new_col.top = above2;
  assign new_col.mid = above;
  assign new_col.bot = s1_q.p;

  // cell 2 is the newest column, cell 0 the oldest
  for (genvar k = 0; k < 3; k++) begin : g_cell
    pewb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .col_i   ((k == 2) ? new_col : cell_col[(k == 2) ? k : k + 1]),
      .col_o   (cell_col[k]),
      .sum_o   (cell_sum[k]),
      .diff_o  (cell_diff[k])
    );
  end

  // ---------------- stage 2: window holds the item ----------------
  logic s2_inner_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q && (!s1_q.pix || s1_q.emit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_inner_q <= s1_q.pix && s1_q.inner;
      s2_last_q  <= !s1_q.pix && s1_q.last;
    end
  end

  logic signed [pewb_pkg::G_W-1:0] gx, gy;
  logic [pewb_pkg::ABS_W-1:0]      ax, ay;

  always_comb begin
    gx = $signed({1'b0, cell_sum[2]}) - $signed({1'b0, cell_sum[0]});
    gy = pewb_pkg::G_W'(cell_diff[0]) + pewb_pkg::G_W'(cell_diff[1])
       + pewb_pkg::G_W'(cell_diff[2]);
    ax = gx[pewb_pkg::G_W-1] ? pewb_pkg::ABS_W'(-gx) : pewb_pkg::ABS_W'(gx);
    ay = gy[pewb_pkg::G_W-1] ? pewb_pkg::ABS_W'(-gy) : pewb_pkg::ABS_W'(gy);
  end

  // ---------------- stage 3: absolute gradients ----------------
  logic                       s3_inner_q, s3_last_q;
  logic [pewb_pkg::ABS_W-1:0] ax_q, ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_inner_q <= s2_inner_q;
      s3_last_q  <= s2_last_q;
      ax_q       <= ax;
      ay_q       <= ay;
    end
  end

  logic [pewb_pkg::PROD_W-1:0] px, py;
  logic [PW-1:0]               qx, qy, mag;

  always_comb begin
    px  = pewb_pkg::PROD_W'(ax_q) * pewb_pkg::DIV3_MUL;
    py  = pewb_pkg::PROD_W'(ay_q) * pewb_pkg::DIV3_MUL;
    qx  = px[pewb_pkg::DIV3_SH +: PW];
    qy  = py[pewb_pkg::DIV3_SH +: PW];
    mag = !s3_inner_q ? '0 : ((qx > qy) ? qx : qy);
  end

  // ---------------- stage 4: output register ----------------
  pewb_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_q.out_pixel      <= (mag < thr_q) ? pewb_pkg::PIX_BLACK : pewb_pkg::PIX_WHITE;
      out_q.edge_magnitude <= mag;
      out_q.frame_last     <= s3_last_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  // the window must not move under an item that is still waiting in stage 2
  a_shift_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> (!v2_q || rdy3))
    else $error("window shifted under a held item");

  // write-back and the next read never meet at one line store address
  a_ram_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (s1_q.col != col_q))
    else $error("line store read and write collide");

  // flush credit exists only once the whole frame is in
  a_flush_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_q != '0) |-> (row_q == h_q))
    else $error("flush credit before frame end");

  // the frame's last result comes from a flush, so it has no magnitude
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_last) |-> (out_data_o.edge_magnitude == '0))
    else $error("frame_last on a pixel result");

  // input stalls only when every pipeline stage is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with room in the pipeline");

endmodule

/* sv/pewb_ram.sv */
// pewb_ram: generic single write port, single read port RAM with registered read
// no dependencies; used for the line stores

module pewb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pewb_cell.sv */
// pewb_cell: one column of the 3x3 window; shifts to its neighbor and gives
// the column sum and bottom-minus-top difference; depends on pewb_pkg

module pewb_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                shift_i,
  input  pewb_pkg::pix_col_t                  col_i,
  output pewb_pkg::pix_col_t                  col_o,
  output logic [pewb_pkg::SUM_W-1:0]          sum_o,
  output logic signed [pewb_pkg::DIFF_W-1:0]  diff_o
);

  pewb_pkg::pix_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o  = col_q;
  assign sum_o  = pewb_pkg::SUM_W'(col_q.top) + pewb_pkg::SUM_W'(col_q.mid)
                + pewb_pkg::SUM_W'(col_q.bot);
  assign diff_o = $signed({1'b0, col_q.bot}) - $signed({1'b0, col_q.top});

endmodule
